/* rtl/pfs_pkg.sv */
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int unsigned PORT_VAL_W = 8;
  localparam int unsigned PORT_CNT_W = 8;

  // Verdict the front can give without any division.
  localparam logic [1:0] CLS_NOT   = 2'd0;
  localparam logic [1:0] CLS_PRIME = 2'd1;
  localparam logic [1:0] CLS_TRIAL = 2'd2;

  typedef struct packed {
    logic [PORT_VAL_W-1:0] value;
    logic                  last_item;
    logic [1:0]            cls;
  } pfs_item_t;

  typedef struct packed {
    logic [PORT_VAL_W-1:0] passed_value;
    logic                  is_prime;
    logic [PORT_CNT_W-1:0] primes_so_far;
    logic                  last_out;
  } pfs_res_t;

endpackage

/* rtl/pfs_fifo.sv */
`timescale 1ns / 1ps

module pfs_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

/* rtl/pfs_front.sv */
`timescale 1ns / 1ps

module pfs_front
  import pfs_pkg::*;
#(
  parameter int unsigned EW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [PORT_VAL_W-1:0] value,
  input  logic                  last_item,
  output logic                  full,
  input  logic                  pop,
  output pfs_item_t             item,
  output logic                  empty
);

  localparam logic [PORT_VAL_W-1:0] MASK = PORT_VAL_W'((9'd1 << EW) - 9'd1);

  logic [PORT_VAL_W-1:0]       val_m;
  pfs_item_t                   cls_item;
  logic [$bits(pfs_item_t)-1:0] rd_bits;

  assign val_m = value & MASK;

  // Small values and even values are settled here; only odd values of five
  // and up need trial division.
  always_comb begin
    cls_item.value     = val_m;
    cls_item.last_item = last_item;
    priority if (val_m < PORT_VAL_W'(2)) begin
      cls_item.cls = CLS_NOT;
    end else if (val_m < PORT_VAL_W'(4)) begin
      cls_item.cls = CLS_PRIME;
    end else if (!val_m[0]) begin
      cls_item.cls = CLS_NOT;
    end else begin
      cls_item.cls = CLS_TRIAL;
    end
  end

  pfs_fifo #(
    .W     ($bits(pfs_item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls_item),
    .full  (full),
    .pop   (pop),
    .rdata (rd_bits),
    .empty (empty)
  );

  assign item = pfs_item_t'(rd_bits);

endmodule

/* rtl/pfs_rem.sv */
`timescale 1ns / 1ps

module pfs_rem #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  shf_r;
  logic [W-1:0]  div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;

  // Restoring division, one dividend bit per cycle, keeping only the remainder.
  always_comb begin
    trial   = {rem_r[W-1:0], shf_r[W-1]};
    rem_nxt = (trial >= {1'b0, div_r}) ? trial - {1'b0, div_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      shf_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      shf_r <= shf_r << 1;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[W-1:0];

endmodule

/* rtl/pfs_back.sv */
`timescale 1ns / 1ps

module pfs_back
  import pfs_pkg::*;
#(
  parameter int unsigned EW        = 8,
  parameter int unsigned MAX_ITEMS = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pfs_item_t item,
  input  logic      q_empty,
  output logic      q_pop,
  output pfs_res_t  res,
  output logic      res_push,
  input  logic      res_full
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 2 * EW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]      state_r, state_nxt;
  pfs_item_t       item_r;
  logic [EW-1:0]   d_r, d_nxt;
  logic [SW-1:0]   sq_r, sq_nxt;
  logic            prime_r, prime_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_upd;
  logic            rem_start;
  logic            rem_done;
  logic [EW-1:0]   rem_val;
  logic [EW-1:0]   v;
  logic [CW+PORT_VAL_W-1:0] cnt_ext;
  logic [EW+PORT_VAL_W-1:0] val_ext;

  assign v = item_r.value[EW-1:0];

  pfs_rem #(
    .W (EW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (v),
    .divisor  (d_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign cnt_upd = (prime_r && (cnt_r < CW'(MAX_ITEMS))) ? cnt_r + CW'(1) : cnt_r;
  assign cnt_ext = {{PORT_VAL_W{1'b0}}, cnt_upd};
  assign val_ext = {{PORT_VAL_W{1'b0}}, v};

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign res_push = (state_r == S_EMIT);

  always_comb begin
    res.passed_value  = val_ext[PORT_VAL_W-1:0];
    res.is_prime      = prime_r;
    res.primes_so_far = cnt_ext[PORT_CNT_W-1:0];
    res.last_out      = item_r.last_item;
  end

  // Odd divisors only, from three while d*d <= v; the square is stepped
  // along with the divisor: (d+2)^2 = d^2 + 4d + 4.
  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    prime_nxt = prime_r;
    cnt_nxt   = cnt_r;
    rem_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          d_nxt  = EW'(3);
          sq_nxt = SW'(9);
          if (item.cls == CLS_TRIAL) begin
            state_nxt = S_TEST;
          end else begin
            prime_nxt = (item.cls == CLS_PRIME);
            state_nxt = S_EMIT;
          end
        end
      end
      S_TEST: begin
        if (sq_r > SW'(v)) begin
          prime_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            d_nxt     = d_r + EW'(2);
            sq_nxt    = sq_r + SW'({d_r, 2'b00}) + SW'(4);
            state_nxt = S_TEST;
          end
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          cnt_nxt   = item_r.last_item ? '0 : cnt_upd;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
    if (q_pop) begin
      item_r <= item;
    end
  end

endmodule

/* rtl/prime_filter_stream.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// in_       request    in_push/in_full  in_value[7:0], in_last_item
// out_      result     out_pop/out_empty out_passed_value[7:0], out_is_prime,
//                                        out_primes_so_far[7:0], out_last_out
//
// Values below four and even values are settled in the front without division.
// Odd values take one remainder run for each odd trial divisor up to the square
// root, on the bit-serial remainder unit; 8-bit values need at most seven divisions.
// Reset is synchronous and empties both queues and clears the prime count.
// With pop stalled, the input stalls once both two-entry queues and the back are full.

module prime_filter_stream
  import pfs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 8,
  parameter int unsigned MAX_ITEMS  = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [PORT_VAL_W-1:0] in_value,
  input  logic                  in_last_item,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [PORT_VAL_W-1:0] out_passed_value,
  output logic                  out_is_prime,
  output logic [PORT_CNT_W-1:0] out_primes_so_far,
  output logic                  out_last_out
);

  // Only the low bits that the port carries can matter.
  localparam int unsigned EW = (VALUE_BITS < PORT_VAL_W) ? VALUE_BITS : PORT_VAL_W;

  pfs_item_t q_item;
  logic      q_empty;
  logic      q_pop;
  pfs_res_t  res;
  logic      res_push;
  logic      res_full;
  logic [$bits(pfs_res_t)-1:0] out_bits;
  pfs_res_t  out_res;

  pfs_front #(
    .EW (EW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .value     (in_value),
    .last_item (in_last_item),
    .full      (in_full),
    .pop       (q_pop),
    .item      (q_item),
    .empty     (q_empty)
  );

  pfs_back #(
    .EW        (EW),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  pfs_fifo #(
    .W     ($bits(pfs_res_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_res           = pfs_res_t'(out_bits);
  assign out_passed_value  = out_res.passed_value;
  assign out_is_prime      = out_res.is_prime;
  assign out_primes_so_far = out_res.primes_so_far;
  assign out_last_out      = out_res.last_out;

endmodule

/* rtl/pfs_chk.sv */
`timescale 1ns / 1ps

module pfs_chk
  import pfs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_pop,
  input logic                  out_empty,
  input logic [PORT_VAL_W-1:0] out_passed_value,
  input logic                  out_is_prime,
  input logic [PORT_CNT_W-1:0] out_primes_so_far
);

  // Nothing may be waiting right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_passed_value < PORT_VAL_W'(2) |-> !out_is_prime)
    else $error("zero or one reported as prime");

  a_even_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_passed_value[0] && out_passed_value > PORT_VAL_W'(2)
    |-> !out_is_prime)
    else $error("even value above two reported as prime");

  // A prime always counts itself, so the count cannot be zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_is_prime |-> out_primes_so_far != '0)
    else $error("prime result with zero count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_passed_value))
    else $error("waiting result changed or vanished");

endmodule

bind prime_filter_stream pfs_chk u_pfs_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_pop           (out_pop),
  .out_empty         (out_empty),
  .out_passed_value  (out_passed_value),
  .out_is_prime      (out_is_prime),
  .out_primes_so_far (out_primes_so_far)
);

/* dv/prime_filter_stream_checker.sv */
`timescale 1ns / 1ps

module prime_filter_stream_checker
  import pfs_pkg::*;
#(
  parameter int unsigned COUNT_CEIL = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [PORT_VAL_W-1:0] in_value,
  input  logic                  in_last_item,
  input  logic                  out_pop,
  input  logic                  out_empty,
  input  logic [PORT_VAL_W-1:0] out_passed_value,
  input  logic                  out_is_prime,
  input  logic [PORT_CNT_W-1:0] out_primes_so_far,
  input  logic                  out_last_out,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    primes_seen,
  output int                    ceiling_hits,
  output int                    runs_closed
);

  pfs_res_t              verdict_q[$];
  logic [PORT_CNT_W-1:0] run_primes;
  int                    mismatches;
  int                    n_checked;
  int                    n_primes;
  int                    n_ceiling;
  int                    n_runs;

  initial begin
    run_primes = '0;
    mismatches = 0;
    n_checked  = 0;
    n_primes   = 0;
    n_ceiling  = 0;
    n_runs     = 0;
  end

  function automatic logic trial_prime(input logic [PORT_VAL_W-1:0] v);
    int d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string fname, input logic [PORT_VAL_W-1:0] want_v,
                             input logic [PORT_VAL_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    pfs_res_t              want;
    logic                  prime_now;
    logic [PORT_CNT_W-1:0] next_count;
    if (!rst_n) begin
      verdict_q.delete();
      run_primes = '0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: value %0d with no request outstanding",
                 out_passed_value);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("passed_value", want.passed_value, out_passed_value);
          check_field("is_prime", want.is_prime, out_is_prime);
          check_field("primes_so_far", want.primes_so_far, out_primes_so_far);
          check_field("last_out", want.last_out, out_last_out);
          n_checked++;
        end
      end
      if (in_push && !in_full) begin
        prime_now  = trial_prime(in_value);
        next_count = run_primes;
        if (prime_now) begin
          n_primes++;
          // Once the count sits at the ceiling, further primes leave it there.
          if (next_count < COUNT_CEIL) next_count++;
          else n_ceiling++;
        end
        want.passed_value  = in_value;
        want.is_prime      = prime_now;
        want.primes_so_far = next_count;
        want.last_out      = in_last_item;
        verdict_q.push_back(want);
        if (in_last_item) begin
          run_primes = '0;
          n_runs++;
        end else begin
          run_primes = next_count;
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= verdict_q.size();
    results_checked <= n_checked;
    primes_seen     <= n_primes;
    ceiling_hits    <= n_ceiling;
    runs_closed     <= n_runs;
  end

endmodule

/* dv/prime_filter_stream_tb.sv */
`timescale 1ns / 1ps

module prime_filter_stream_tb;
  import pfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_ITEMS     = 80;
  localparam int TARGET_ITEMS   = 600;

  typedef struct packed {
    logic [PORT_VAL_W-1:0] value;
    logic                  last;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [PORT_VAL_W-1:0] in_value;
  logic                  in_last_item;
  logic                  out_pop;
  logic                  out_empty;
  logic [PORT_VAL_W-1:0] out_passed_value;
  logic                  out_is_prime;
  logic [PORT_CNT_W-1:0] out_primes_so_far;
  logic                  out_last_out;

  int fail_count;
  int pending;
  int results_checked;
  int primes_seen;
  int ceiling_hits;
  int runs_closed;

  logic hold_active;
  logic tail_phase;
  int   quiet_cycles;

  request_t    request_q[$];
  byte unsigned prime_tab [54] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61,
    67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139,
    149, 151, 157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223,
    227, 229, 233, 239, 241, 251
  };

  prime_filter_stream dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_value          (in_value),
    .in_last_item      (in_last_item),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_passed_value  (out_passed_value),
    .out_is_prime      (out_is_prime),
    .out_primes_so_far (out_primes_so_far),
    .out_last_out      (out_last_out)
  );

  prime_filter_stream_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_value          (in_value),
    .in_last_item      (in_last_item),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_passed_value  (out_passed_value),
    .out_is_prime      (out_is_prime),
    .out_primes_so_far (out_primes_so_far),
    .out_last_out      (out_last_out),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked),
    .primes_seen       (primes_seen),
    .ceiling_hits      (ceiling_hits),
    .runs_closed       (runs_closed)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void add_request(input int v, input logic last);
    request_t r;
    r.value = v[PORT_VAL_W-1:0];
    r.last  = last;
    request_q.push_back(r);
  endfunction

  // Mix of primes, the values up to four, odd composites that make the divider
  // run long, and fully random values.
  function automatic int pick_value();
    int r;
    int p;
    int q;
    r = $urandom_range(0, 99);
    if (r < 35) return prime_tab[$urandom_range(0, 53)];
    if (r < 45) return $urandom_range(0, 4);
    if (r < 65) begin
      p = prime_tab[$urandom_range(1, 5)];
      do q = prime_tab[$urandom_range(1, 53)]; while (p * q > 255);
      return p * q;
    end
    return $urandom_range(0, 255);
  endfunction

  task automatic build_requests();
    int n;
    int run_len;
    // Directed: extremes, small values, prime squares and run boundaries.
    add_request(0, 1'b0);
    add_request(1, 1'b0);
    add_request(2, 1'b0);
    add_request(3, 1'b0);
    add_request(4, 1'b0);
    add_request(255, 1'b0);
    add_request(251, 1'b0);
    add_request(254, 1'b0);
    add_request(128, 1'b0);
    add_request(127, 1'b0);
    add_request(169, 1'b0);
    add_request(121, 1'b0);
    add_request(49, 1'b0);
    add_request(25, 1'b0);
    add_request(9, 1'b0);
    add_request(253, 1'b0);
    add_request(170, 1'b0);
    add_request(85, 1'b1);
    add_request(241, 1'b1);
    add_request(1, 1'b1);
    add_request(2, 1'b0);
    add_request(0, 1'b1);
    // One long run, nearly all primes, so the count reaches its ceiling.
    for (n = 0; n < 160; n++) begin
      if ($urandom_range(0, 9) != 0) add_request(prime_tab[$urandom_range(0, 53)], n == 159);
      else add_request($urandom_range(0, 255), n == 159);
    end
    while (request_q.size() < TARGET_ITEMS) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      for (n = 0; n < run_len; n++) add_request(pick_value(), n == run_len - 1);
    end
  endtask

  // Sender: reset, then offer every request, with random gaps outside the tail and the hold.
  initial begin : sender
    int idx;
    int steady_left;
    int r;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_value     = '0;
    in_last_item = 1'b0;
    tail_phase   = 1'b0;
    steady_left  = 0;
    build_requests();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (idx = 0; idx < request_q.size(); idx++) begin
      if (idx == request_q.size() - TAIL_ITEMS) tail_phase <= 1'b1;
      if (idx < request_q.size() - TAIL_ITEMS && !hold_active) begin
        if (steady_left > 0) begin
          steady_left--;
        end else begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            in_push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
          end else if (r == 9) begin
            steady_left = $urandom_range(20, 60);
          end
        end
      end
      in_push      <= 1'b1;
      in_value     <= request_q[idx].value;
      in_last_item <= request_q[idx].last;
      @(posedge clk);
      while (in_full) @(posedge clk);
    end
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // Allow a stray result to surface before the verdict.
    repeat (100) @(posedge clk);
    $display("Sent %0d requests in %0d runs; %0d primes, %0d of them past the count ceiling.",
             request_q.size(), runs_closed, primes_seen, ceiling_hits);
    $display("Checked %0d results, including a long output stall that filled the block.",
             results_checked);
    if (fail_count == 0) begin
      $display("prime_filter_stream verification clean");
    end else begin
      $display("prime_filter_stream verification failed");
    end
    $finish;
  end

  // Receiver: random pop gaps, one long hold-off to back the block up.
  initial begin : receiver
    int  steady_left;
    int  r;
    logic held;
    out_pop     = 1'b0;
    hold_active = 1'b0;
    steady_left = 0;
    held        = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (!held && results_checked >= 150) begin
        held = 1'b1;
        hold_active <= 1'b1;
        out_pop     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end else if (!tail_phase) begin
        if (steady_left > 0) begin
          steady_left--;
        end else begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            out_pop <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
          end else if (r == 9) begin
            steady_left = $urandom_range(20, 60);
          end
        end
      end
      out_pop <= 1'b1;
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("prime_filter_stream verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
